### rtl/mitc_pkg.sv
// ----------------------------------------------------------------------------
// mitc_pkg
// shared types and constants of the multichannel impact trigger capture
// ----------------------------------------------------------------------------
package mitc_pkg;

  localparam int unsigned MAX_CHANNELS = 16;
  localparam int unsigned WORD_W       = 16;
  localparam int unsigned CH_W         = 4;
  localparam int unsigned TIME_W       = 64;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned LIMIT_W      = 10;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 10;
  localparam int unsigned S_DATA_W     = 80;
  localparam int unsigned M_DATA_W     = 72;

  // command codes carried in tuser
  localparam logic CMD_IRQ  = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_LIMIT = 2'd2;

  // reset values of the configuration registers
  localparam logic [CNT_W-1:0]   RST_CHANNELS    = 5'd9;
  localparam logic               RST_ACTIVE_HIGH = 1'b0;
  localparam logic [LIMIT_W-1:0] RST_DRAIN_LIMIT = 10'd250;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic ready;  // input slot open
    logic eval;   // update trigger state from the captured beat
    logic emit;   // move one pending channel into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pend_empty;  // no channel left to emit
    logic slot_free;   // output register can take a beat
  } sts_t;

endpackage

### rtl/mitc_ctrl.sv
// ----------------------------------------------------------------------------
// mitc_ctrl
// sequencer: capture a beat, evaluate, emit triggers one per unstalled cycle
// ----------------------------------------------------------------------------
module mitc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  mitc_pkg::sts_t  sts_i,
  output mitc_pkg::cmd_t  cmd_o
);

  mitc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mitc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mitc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = mitc_pkg::ST_EVAL;
      end
      mitc_pkg::ST_EVAL: begin
        state_d = mitc_pkg::ST_EMIT;
      end
      mitc_pkg::ST_EMIT: begin
        if (sts_i.pend_empty) state_d = mitc_pkg::ST_IDLE;
      end
      default: state_d = mitc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      mitc_pkg::ST_IDLE: cmd_o.ready = 1'b1;
      mitc_pkg::ST_EVAL: cmd_o.eval  = 1'b1;
      mitc_pkg::ST_EMIT: cmd_o.emit  = !sts_i.pend_empty && sts_i.slot_free;
      default:           cmd_o       = '0;
    endcase
  end

endmodule

### rtl/mitc_dp.sv
// ----------------------------------------------------------------------------
// mitc_dp
// datapath: config registers, trigger state, pending mask and output register
// ----------------------------------------------------------------------------
module mitc_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mitc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mitc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_cmd_i,
  input  logic [mitc_pkg::WORD_W-1:0]         in_raw_i,
  input  logic [mitc_pkg::TIME_W-1:0]         in_time_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [mitc_pkg::CH_W-1:0]           out_ch_o,
  output logic [mitc_pkg::TIME_W-1:0]         out_time_o,
  output logic                                out_last_o,
  input  mitc_pkg::cmd_t                      cmd_i,
  output mitc_pkg::sts_t                      sts_o
);

  // configuration
  logic [mitc_pkg::CNT_W-1:0]   chans_q;
  logic                         act_high_q;
  logic [mitc_pkg::LIMIT_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chans_q    <= mitc_pkg::RST_CHANNELS;
      act_high_q <= mitc_pkg::RST_ACTIVE_HIGH;
      limit_q    <= mitc_pkg::RST_DRAIN_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mitc_pkg::CFG_CHANNELS:    chans_q    <= cfg_data_i[mitc_pkg::CNT_W-1:0];
        mitc_pkg::CFG_ACTIVE_HIGH: act_high_q <= cfg_data_i[0];
        mitc_pkg::CFG_DRAIN_LIMIT: limit_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured input beat
  logic                          cmd_q;
  logic [mitc_pkg::WORD_W-1:0]   raw_q;
  logic [mitc_pkg::TIME_W-1:0]   time_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && in_valid_i) begin
      cmd_q  <= in_cmd_i;
      raw_q  <= in_raw_i;
      time_q <= in_time_i;
    end
  end

  // triggered mask of the captured word
  logic [mitc_pkg::WORD_W-1:0] present;
  logic [mitc_pkg::WORD_W-1:0] trig_mask;

  always_comb begin
    if (chans_q >= mitc_pkg::CNT_W'(mitc_pkg::WORD_W)) begin
      present = '1;
    end else begin
      present = (mitc_pkg::WORD_W'(1) << chans_q[mitc_pkg::CH_W-1:0])
                - mitc_pkg::WORD_W'(1);
    end
    trig_mask = (act_high_q ? raw_q : ~raw_q) & present;
  end

  // trigger state
  logic                          drain_q, drain_d;
  logic [mitc_pkg::WORD_W-1:0]   rep_q, rep_d;
  logic [mitc_pkg::LIMIT_W-1:0]  poll_q, poll_d;
  logic [mitc_pkg::WORD_W-1:0]   pend_q, pend_d;
  logic [mitc_pkg::LIMIT_W-1:0]  poll_inc;
  logic [mitc_pkg::LIMIT_W-1:0]  limit_eff;

  // lowest pending channel
  logic [mitc_pkg::WORD_W-1:0]   low_hot;
  logic [mitc_pkg::CH_W-1:0]     low_idx;
  logic [mitc_pkg::WORD_W-1:0]   pend_rest;

  always_comb begin
    low_hot   = pend_q & (~pend_q + mitc_pkg::WORD_W'(1));
    pend_rest = pend_q & ~low_hot;
    low_idx   = '0;
    for (int i = 0; i < mitc_pkg::WORD_W; i++) begin
      if (low_hot[i]) low_idx = mitc_pkg::CH_W'(i);
    end
  end

  always_comb begin
    drain_d   = drain_q;
    rep_d     = rep_q;
    poll_d    = poll_q;
    pend_d    = pend_q;
    poll_inc  = poll_q + mitc_pkg::LIMIT_W'(1);
    limit_eff = (limit_q == '0) ? mitc_pkg::LIMIT_W'(1) : limit_q;
    if (cmd_i.eval) begin
      pend_d = '0;
      if (cmd_q == mitc_pkg::CMD_IRQ) begin
        if (!drain_q) begin
          pend_d  = trig_mask;
          rep_d   = trig_mask;
          poll_d  = '0;
          drain_d = 1'b1;
        end
      end else if (drain_q) begin
        poll_d = poll_inc;
        if (trig_mask == '0) begin
          drain_d = 1'b0;
          rep_d   = '0;
        end else begin
          pend_d = trig_mask & ~rep_q;
          rep_d  = trig_mask;
          if (poll_inc >= limit_eff) drain_d = 1'b0;
        end
      end
    end else if (cmd_i.emit) begin
      pend_d = pend_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      rep_q   <= '0;
      poll_q  <= '0;
      pend_q  <= '0;
    end else begin
      drain_q <= drain_d;
      rep_q   <= rep_d;
      poll_q  <= poll_d;
      pend_q  <= pend_d;
    end
  end

  // output register
  logic                         oval_q;
  logic [mitc_pkg::CH_W-1:0]    och_q;
  logic [mitc_pkg::TIME_W-1:0]  otime_q;
  logic                         olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else if (cmd_i.emit) begin
      oval_q <= 1'b1;
    end else if (out_ready_i) begin
      oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      och_q   <= low_idx;
      otime_q <= time_q;
      olast_q <= (pend_rest == '0);
    end
  end

  assign out_valid_o     = oval_q;
  assign out_ch_o        = och_q;
  assign out_time_o      = otime_q;
  assign out_last_o      = olast_q;
  assign sts_o.pend_empty = (pend_q == '0);
  assign sts_o.slot_free  = !oval_q || out_ready_i;

endmodule

### rtl/multichannel_impact_trigger_capture.sv
// ----------------------------------------------------------------------------
// multichannel_impact_trigger_capture
// turns interrupt and poll beats with a comparator word into channel triggers
// ----------------------------------------------------------------------------
// an input beat is accepted in the idle state, then evaluated, then its
// triggers (up to 16) are serialized one at a time through the single
// output register, where a stall on the output holds the next trigger; the
// next beat is taken only once the pending mask is seen empty. an interrupt
// while idle emits one beat per triggered channel, lowest first, and starts
// draining; polls while draining emit newly active channels, rearm channels
// back at rest, and end draining on an all-quiet word or when the poll count
// reaches drain_limit. interrupts while draining and polls while idle give
// no beats. config must be written through cfg_we_i / cfg_idx_i / cfg_data_i
// only while the block is idle; the block itself does not enforce this.
module multichannel_impact_trigger_capture (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write port
  input  logic                                cfg_we_i,
  input  logic [mitc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mitc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [mitc_pkg::S_DATA_W-1:0]       s_axis_tdata_i,  // raw_bits, time_us
  input  logic                                s_axis_tuser_i,  // command
  // output stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [mitc_pkg::M_DATA_W-1:0]       m_axis_tdata_o,  // channel, trigger_time, pad
  output logic                                m_axis_tlast_o
);

  mitc_pkg::cmd_t cmd;
  mitc_pkg::sts_t sts;

  logic [mitc_pkg::CH_W-1:0]   out_ch;
  logic [mitc_pkg::TIME_W-1:0] out_time;

  // sequencer
  mitc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // mask logic, trigger state and output register
  mitc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_cmd_i    (s_axis_tuser_i),
    .in_raw_i    (s_axis_tdata_i[mitc_pkg::WORD_W-1:0]),
    .in_time_i   (s_axis_tdata_i[mitc_pkg::S_DATA_W-1:mitc_pkg::WORD_W]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ch_o    (out_ch),
    .out_time_o  (out_time),
    .out_last_o  (m_axis_tlast_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  assign s_axis_tready_o = cmd.ready;

  // channel in the low nibble, timestamp above, zero pad to whole bytes
  assign m_axis_tdata_o = {
    {(mitc_pkg::M_DATA_W - mitc_pkg::TIME_W - mitc_pkg::CH_W){1'b0}},
    out_time,
    out_ch
  };

  // idle never leaves channels behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> sts.pend_empty)
    else $error("input open while triggers still pending");

  // an accepted beat is followed by evaluation, not another accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (cmd.eval && !s_axis_tready_o))
    else $error("accepted beat not evaluated next cycle");

  // a trigger only moves into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (sts.slot_free && !sts.pend_empty))
    else $error("emit without free slot or pending channel");

endmodule
